@@ sv/longest_word_tracker_core_defines.svh @@
// ----------------------------------------------------------------------------
// longest_word_tracker_core assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef LONGEST_WORD_TRACKER_CORE_DEFINES_SVH
`define LONGEST_WORD_TRACKER_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define LWT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define LWT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ sv/lwt_pkg.sv @@
// ----------------------------------------------------------------------------
// lwt_pkg
// Types and constants shared by the longest word tracker modules.
// ----------------------------------------------------------------------------
package lwt_pkg;

    localparam int BANK_SIZE = 64;
    localparam int POS_W     = 6;
    localparam int ADDR_W    = POS_W + 1;
    localparam int DEPTH     = 2 * BANK_SIZE;
    localparam int LEN_W     = 7;
    localparam int CNT_W     = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_mem_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_mem_rd;

    typedef struct packed {
        logic             start;
        logic             bank;
        logic [LEN_W-1:0] len;
        logic [CNT_W-1:0] cnt;
        logic             trunc;
    } t_rep_req;

    typedef struct packed {
        logic [7:0]       word_byte;
        logic [LEN_W-1:0] longest_length;
        logic [CNT_W-1:0] occurrences;
        logic             truncated;
        logic             last;
    } t_result;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

@@ sv/longest_word_tracker_core.sv @@
// ----------------------------------------------------------------------------
// longest_word_tracker_core
// Streams text bytes, tracks the longest word and its count, reports it.
// ----------------------------------------------------------------------------
// Text bytes (tuser 0) are taken one per cycle; each non-blank byte is
// written into the collecting bank of a 128-byte two-bank store while the
// same position of the longest word is read back and compared in the next
// cycle, the result forwarded into the next word end. An end-of-text beat
// (tuser 1) closes the pending word and starts the report: one output beat
// per byte of the longest word (a single zero beat when no word was seen),
// one per cycle while the output buffer has room, limited by the store's
// single read port; tlast marks the final beat. Input tready is low from the
// cycle after end of text until the final store read is issued; a two-entry
// output buffer decouples output stalls.
// All tracking state returns to reset after each report.
// ----------------------------------------------------------------------------
`include "longest_word_tracker_core_defines.svh"

module longest_word_tracker_core #(
    parameter int MAX_WORD = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] word_byte, [14:8] longest_length,
                                        // [30:15] occurrences, [31] truncated
    output logic        m_axis_tlast    // last_of_report
);

    logic              accept;
    logic              rep_busy;
    logic [7:0]        rd_data;
    lwt_pkg::t_mem_wr  trk_wr;
    lwt_pkg::t_mem_rd  trk_rd, rep_rd, mem_rd;
    lwt_pkg::t_rep_req rep_req;
    lwt_pkg::t_result  result;

    assign s_axis_tready = !rep_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign mem_rd        = rep_rd.en ? rep_rd : trk_rd;

    lwt_track #(
        .MAX_WORD (MAX_WORD)
    ) u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept),
        .i_kind    (s_axis_tuser),
        .i_byte    (s_axis_tdata),
        .i_rd_data (rd_data),
        .o_wr      (trk_wr),
        .o_rd      (trk_rd),
        .o_rep     (rep_req)
    );

    lwt_store u_store (
        .i_clk     (i_clk),
        .i_wr      (trk_wr),
        .i_rd      (mem_rd),
        .o_rd_data (rd_data)
    );

    lwt_report u_report (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rep     (rep_req),
        .i_rd_data (rd_data),
        .i_ready   (m_axis_tready),
        .o_rd      (rep_rd),
        .o_busy    (rep_busy),
        .o_valid   (m_axis_tvalid),
        .o_result  (result)
    );

    assign m_axis_tdata = {result.truncated, result.occurrences,
                           result.longest_length, result.word_byte};
    assign m_axis_tlast = result.last;

    `LWT_ASSERT_IMPL(a_rd_port_excl, rep_rd.en, !trk_rd.en, "store read port conflict")
    `LWT_ASSERT_IMPL(a_no_wr_in_rep, rep_busy, !trk_wr.en, "store write during report")

endmodule

@@ sv/lwt_store.sv @@
// ----------------------------------------------------------------------------
// lwt_store
// Two-bank word memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lwt_store (
    input  logic             i_clk,
    input  lwt_pkg::t_mem_wr i_wr,
    input  lwt_pkg::t_mem_rd i_rd,
    output logic [7:0]       o_rd_data
);

    logic [7:0] mem [lwt_pkg::DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/lwt_track.sv @@
// ----------------------------------------------------------------------------
// lwt_track
// Word splitting, store writes, prefix compare against the longest word
// and longest/count bookkeeping. Hands a report request on end of text.
// ----------------------------------------------------------------------------
`include "longest_word_tracker_core_defines.svh"

module lwt_track #(
    parameter int MAX_WORD = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_kind,
    input  logic [7:0]        i_byte,
    input  logic [7:0]        i_rd_data,
    output lwt_pkg::t_mem_wr  o_wr,
    output lwt_pkg::t_mem_rd  o_rd,
    output lwt_pkg::t_rep_req o_rep
);

    localparam logic [lwt_pkg::LEN_W-1:0] MAX_LEN = lwt_pkg::LEN_W'(MAX_WORD);

    logic                       r_bank, n_bank;
    logic [lwt_pkg::LEN_W-1:0]  r_cur, n_cur;
    logic [lwt_pkg::LEN_W-1:0]  r_best, n_best;
    logic [lwt_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                       r_peq, n_peq;
    logic                       r_ovf, n_ovf;
    logic                       r_cmp_vld, n_cmp_vld;
    logic [7:0]                 r_cmp_byte, n_cmp_byte;

    logic                       peq_eff;
    logic                       e_bank;
    logic [lwt_pkg::LEN_W-1:0]  e_best;
    logic [lwt_pkg::CNT_W-1:0]  e_cnt;

    // compare of the previous byte lands now; forward it
    assign peq_eff = r_peq && !(r_cmp_vld && (i_rd_data != r_cmp_byte));

    always_comb begin
        e_bank = r_bank;
        e_best = r_best;
        e_cnt  = r_cnt;
        if (r_cur != '0) begin
            if (r_cur > r_best) begin
                e_bank = ~r_bank;
                e_best = r_cur;
                e_cnt  = lwt_pkg::CNT_W'(1);
            end else if ((r_cur == r_best) && peq_eff && (r_cnt != lwt_pkg::CNT_MAX)) begin
                e_cnt = r_cnt + lwt_pkg::CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_bank     = r_bank;
        n_cur      = r_cur;
        n_best     = r_best;
        n_cnt      = r_cnt;
        n_peq      = peq_eff;
        n_ovf      = r_ovf;
        n_cmp_vld  = 1'b0;
        n_cmp_byte = r_cmp_byte;
        o_wr.en    = 1'b0;
        o_wr.addr  = {~r_bank, r_cur[lwt_pkg::POS_W-1:0]};
        o_wr.data  = i_byte;
        o_rd.en    = 1'b0;
        o_rd.addr  = {r_bank, r_cur[lwt_pkg::POS_W-1:0]};
        o_rep      = '0;
        if (i_valid) begin
            if (i_kind == lwt_pkg::KIND_END) begin
                o_rep.start = 1'b1;
                o_rep.bank  = e_bank;
                o_rep.len   = e_best;
                o_rep.cnt   = e_cnt;
                o_rep.trunc = r_ovf;
                n_bank      = 1'b0;
                n_cur       = '0;
                n_best      = '0;
                n_cnt       = '0;
                n_peq       = 1'b1;
                n_ovf       = 1'b0;
            end else if (lwt_pkg::is_blank(i_byte)) begin
                n_bank = e_bank;
                n_best = e_best;
                n_cnt  = e_cnt;
                n_cur  = '0;
                n_peq  = 1'b1;
            end else if (r_cur >= MAX_LEN) begin
                n_ovf = 1'b1;
            end else begin
                o_wr.en = 1'b1;
                if (r_cur < r_best) begin
                    o_rd.en    = 1'b1;
                    n_cmp_vld  = 1'b1;
                    n_cmp_byte = i_byte;
                end
                n_cur = r_cur + lwt_pkg::LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank    <= 1'b0;
            r_cur     <= '0;
            r_best    <= '0;
            r_cnt     <= '0;
            r_peq     <= 1'b1;
            r_ovf     <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_bank    <= n_bank;
            r_cur     <= n_cur;
            r_best    <= n_best;
            r_cnt     <= n_cnt;
            r_peq     <= n_peq;
            r_ovf     <= n_ovf;
            r_cmp_vld <= n_cmp_vld;
        end
        r_cmp_byte <= n_cmp_byte;
    end

    `LWT_ASSERT_ALWAYS(a_cur_bound, r_cur <= MAX_LEN, "current word longer than MAX_WORD")
    `LWT_ASSERT_IMPL(a_best_cnt, r_best != '0, r_cnt != '0, "longest word with zero count")
    `LWT_ASSERT_IMPL(a_cmp_in_word, r_cmp_vld, r_cur != '0, "compare pending with no word")

endmodule

@@ sv/lwt_report.sv @@
// ----------------------------------------------------------------------------
// lwt_report
// Report sequencer: reads the longest word from the store one byte per
// cycle while there is room, queueing beats in a two-entry output buffer.
// ----------------------------------------------------------------------------
`include "longest_word_tracker_core_defines.svh"

module lwt_report (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lwt_pkg::t_rep_req i_rep,
    input  logic [7:0]        i_rd_data,
    input  logic              i_ready,
    output lwt_pkg::t_mem_rd  o_rd,
    output logic              o_busy,
    output logic              o_valid,
    output lwt_pkg::t_result  o_result
);

    logic                      r_busy, n_busy;
    logic                      r_bank;
    logic                      r_zero;
    logic [lwt_pkg::LEN_W-1:0] r_pos, n_pos;
    logic [lwt_pkg::LEN_W-1:0] r_n;
    lwt_pkg::t_result          r_meta;

    logic                      r_fl_vld;
    logic                      r_fl_zero;
    lwt_pkg::t_result          r_fl, n_fl;

    lwt_pkg::t_result          r_fifo [2];
    logic                      r_wptr, r_rptr;
    logic [1:0]                r_cnt;

    logic                      pop, issue, is_last;
    logic [1:0]                occ_after;
    lwt_pkg::t_result          push_beat;

    assign pop       = (r_cnt != 2'd0) && i_ready;
    assign occ_after = r_cnt - {1'b0, pop};
    assign issue     = r_busy && ((occ_after + {1'b0, r_fl_vld}) < 2'd2);
    assign is_last   = (r_pos + lwt_pkg::LEN_W'(1)) == r_n;

    assign o_rd.en   = issue && !r_zero;
    assign o_rd.addr = {r_bank, r_pos[lwt_pkg::POS_W-1:0]};
    assign o_busy    = r_busy;
    assign o_valid   = r_cnt != 2'd0;
    assign o_result  = r_fifo[r_rptr];

    always_comb begin
        push_beat           = r_fl;
        push_beat.word_byte = r_fl_zero ? 8'h00 : i_rd_data;
    end

    always_comb begin
        n_fl      = r_meta;
        n_fl.last = is_last;
    end

    always_comb begin
        n_busy = r_busy;
        n_pos  = r_pos;
        if (issue) begin
            n_pos = r_pos + lwt_pkg::LEN_W'(1);
            if (is_last) begin
                n_busy = 1'b0;
            end
        end else if (i_rep.start) begin
            n_busy = 1'b1;
            n_pos  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_fl_vld <= 1'b0;
            r_wptr   <= 1'b0;
            r_rptr   <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_busy   <= n_busy;
            r_fl_vld <= issue;
            if (r_fl_vld) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, r_fl_vld} - {1'b0, pop};
        end
        r_pos <= n_pos;
        if (i_rep.start && !r_busy) begin
            r_bank <= i_rep.bank;
            r_zero <= i_rep.len == '0;
            r_n    <= (i_rep.len == '0) ? lwt_pkg::LEN_W'(1) : i_rep.len;
            r_meta <= '{word_byte: 8'h00, longest_length: i_rep.len,
                        occurrences: i_rep.cnt, truncated: i_rep.trunc, last: 1'b0};
        end
        if (issue) begin
            r_fl      <= n_fl;
            r_fl_zero <= r_zero;
        end
        if (r_fl_vld) begin
            r_fifo[r_wptr] <= push_beat;
        end
    end

    `LWT_ASSERT_ALWAYS(a_fifo_bound, r_cnt <= 2'd2, "output buffer count out of range")
    `LWT_ASSERT_IMPL(a_push_room, r_fl_vld, occ_after < 2'd2, "read data with full buffer")
    `LWT_ASSERT_IMPL(a_start_idle, i_rep.start, !r_busy, "report request while busy")

endmodule
